// File: rtl/hsl_pkg.sv
// hsl_pkg: shared constants and types of the hsl to rgb converter
// depends on nothing; used by the interfaces, hsl_chan and the top level
package hsl_pkg;

  // configuration register indices
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_SATURATION = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LIGHTNESS  = 2'd1;

  localparam logic [7:0] SATURATION_RESET = 8'd252;
  localparam logic [7:0] LIGHTNESS_RESET  = 8'd128;

  // hue sector bounds in degrees
  localparam logic [8:0] HUE_60  = 9'd60;
  localparam logic [8:0] HUE_120 = 9'd120;
  localparam logic [8:0] HUE_180 = 9'd180;
  localparam logic [8:0] HUE_240 = 9'd240;
  localparam logic [8:0] HUE_300 = 9'd300;
  localparam logic [8:0] HUE_360 = 9'd360;
  localparam logic [8:0] HUE_480 = 9'd480;

  // full channel weight
  localparam logic [5:0] W_FULL = 6'd60;

  // common denominator 255 * 2 * 60
  localparam logic [14:0] DEN = 15'd30600;
  // largest numerator kept: 256 * DEN - 1, still maps to 255
  localparam logic [22:0] NUM_MAX = 23'd7833599;
  // ceil(2^38 / DEN): exact floor division for numerators below 2^23
  localparam logic [23:0] RECIP = 24'd8982939;
  localparam int RecipShift = 38;

  // stage load enables for the channel datapath
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } hsl_adv_t;

endpackage

// File: rtl/hsl_if.sv
// hsl_if: valid/ready channel interfaces for hue input, rgb output and register writes
// depends on hsl_pkg for the register index width

interface hsl_hue_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue;
  modport source (output valid, output hue, input ready);
  modport sink (input valid, input hue, output ready);
endinterface

interface hsl_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface hsl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [hsl_pkg::CfgIdxW-1:0]  index;
  logic [7:0]                   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/hsl_to_rgb_converter.sv
// hsl_to_rgb_converter: hue in degrees to 8-bit rgb, saturation and lightness from registers
// a hue transaction passes through every stage below before its rgb result is valid; throughput
// one hue per cycle while the rgb output is not stalled
// rate is set by the four-stage pipeline (sector decode, numerator, reciprocal multiply, output)
// a stalled output holds its stage; upstream bubbles are squeezed out
// reset (rst, synchronous): pipeline emptied, saturation 252, lightness 128
// depends on hsl_pkg, hsl_if and hsl_chan
module hsl_to_rgb_converter (
  input  logic      clk,
  input  logic      rst,
  hsl_hue_if.sink   hue_ch,
  hsl_cfg_if.sink   cfg,
  hsl_rgb_if.source rgb_ch
);
  import hsl_pkg::*;

  // configuration registers, always ready for a write transaction
  logic [7:0] saturation;
  logic [7:0] lightness;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= SATURATION_RESET;
      lightness  <= LIGHTNESS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SATURATION: saturation <= cfg.data;
        REG_LIGHTNESS:  lightness  <= cfg.data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // per-stage valid bits and ready chain; a stage takes new data when empty
  // or when the stage behind it moves on
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  hsl_adv_t adv;

  assign rdy4 = !v4 || rgb_ch.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign hue_ch.ready = rdy1;
  assign rgb_ch.valid = v4;

  assign adv.s2 = rdy2 && v1;
  assign adv.s3 = rdy3 && v2;
  assign adv.s4 = rdy4 && v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= hue_ch.valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  // stage one: hue mod 120, secondary weight, sector ordering, span * saturation
  logic [8:0]  hmod_wide;
  logic [6:0]  hmod;
  logic [6:0]  dist60;
  logic [5:0]  k;
  logic [5:0]  wr_next, wg_next, wb_next;
  logic [9:0]  two_l;
  logic [7:0]  dev;
  logic [7:0]  span;
  logic [15:0] span_sat_next;

  always_comb begin
    if (hue_ch.hue >= HUE_480) begin
      hmod_wide = hue_ch.hue - HUE_480;
    end else if (hue_ch.hue >= HUE_360) begin
      hmod_wide = hue_ch.hue - HUE_360;
    end else if (hue_ch.hue >= HUE_240) begin
      hmod_wide = hue_ch.hue - HUE_240;
    end else if (hue_ch.hue >= HUE_120) begin
      hmod_wide = hue_ch.hue - HUE_120;
    end else begin
      hmod_wide = hue_ch.hue;
    end
    hmod = hmod_wide[6:0];

    // k = 60 - |hmod - 60|
    if (hmod >= 7'(W_FULL)) begin
      dist60 = hmod - 7'(W_FULL);
    end else begin
      dist60 = 7'(W_FULL) - hmod;
    end
    k = W_FULL - dist60[5:0];

    // 60-degree sector picks where chroma, secondary and zero go
    if (hue_ch.hue < HUE_60) begin
      wr_next = W_FULL; wg_next = k;      wb_next = '0;
    end else if (hue_ch.hue < HUE_120) begin
      wr_next = k;      wg_next = W_FULL; wb_next = '0;
    end else if (hue_ch.hue < HUE_180) begin
      wr_next = '0;     wg_next = W_FULL; wb_next = k;
    end else if (hue_ch.hue < HUE_240) begin
      wr_next = '0;     wg_next = k;      wb_next = W_FULL;
    end else if (hue_ch.hue < HUE_300) begin
      wr_next = k;      wg_next = '0;     wb_next = W_FULL;
    end else begin
      wr_next = W_FULL; wg_next = '0;     wb_next = k;
    end

    // span = 255 - |2L - 255|
    two_l = {1'b0, lightness, 1'b0};
    if (two_l >= 10'd255) begin
      dev = 8'(two_l - 10'd255);
    end else begin
      dev = 8'(10'd255 - two_l);
    end
    span          = 8'd255 - dev;
    span_sat_next = span * saturation;
  end

  logic [5:0]  wr, wg, wb;
  logic [7:0]  light1;
  logic [15:0] span_sat;

  always_ff @(posedge clk) begin
    if (rdy1 && hue_ch.valid) begin
      wr       <= wr_next;
      wg       <= wg_next;
      wb       <= wb_next;
      light1   <= lightness;
      span_sat <= span_sat_next;
    end
  end

  // stages two to four, one datapath per channel
  hsl_chan u_red (
    .clk      (clk),
    .adv      (adv),
    .light    (light1),
    .span_sat (span_sat),
    .weight   (wr),
    .level    (rgb_ch.red)
  );

  hsl_chan u_green (
    .clk      (clk),
    .adv      (adv),
    .light    (light1),
    .span_sat (span_sat),
    .weight   (wg),
    .level    (rgb_ch.green)
  );

  hsl_chan u_blue (
    .clk      (clk),
    .adv      (adv),
    .light    (light1),
    .span_sat (span_sat),
    .weight   (wb),
    .level    (rgb_ch.blue)
  );

endmodule

// File: rtl/hsl_chan.sv
// hsl_chan: one colour channel, stages two to four of the pipeline
// depends on hsl_pkg (constants, hsl_adv_t)
module hsl_chan (
  input  logic              clk,
  input  hsl_pkg::hsl_adv_t adv,
  input  logic [7:0]        light,
  input  logic [15:0]       span_sat,
  input  logic [5:0]        weight,
  output logic [7:0]        level
);
  import hsl_pkg::*;

  logic signed [7:0]  coef;
  logic signed [24:0] term;
  logic [22:0]        base;
  logic signed [25:0] num;
  logic [22:0]        num_clamped;

  logic [22:0] num_q;
  logic [46:0] prod;

  // numerator: L * DEN + span * S * (2w - 60)
  always_comb begin
    coef = $signed({1'b0, weight, 1'b0}) - 8'sd60;
    term = $signed({1'b0, span_sat}) * coef;
    base = 23'(light) * 23'(DEN);
    num  = $signed({3'b000, base}) + 26'(term);
    if (num[25]) begin
      num_clamped = '0;
    end else if (num[24:0] > 25'(NUM_MAX)) begin
      num_clamped = NUM_MAX;
    end else begin
      num_clamped = num[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      num_q <= num_clamped;
    end
    if (adv.s3) begin
      prod <= num_q * RECIP;
    end
    if (adv.s4) begin
      level <= prod[RecipShift+7:RecipShift];
    end
  end

endmodule
